>>> src/ptp_pkg.sv
package ptp_pkg;

   // event codes
   localparam logic [3:0] FUNC_STOP         = 4'd0;
   localparam logic [3:0] FUNC_NEXT_PATTERN = 4'd1;
   localparam logic [3:0] FUNC_NAMED        = 4'd2;
   localparam logic [3:0] FUNC_QUEUE_PT     = 4'd3;
   localparam logic [3:0] FUNC_INTENSITY    = 4'd4;
   localparam logic [3:0] FUNC_ADC          = 4'd5;
   localparam logic [3:0] FUNC_BURST_START  = 4'd6;
   localparam logic [3:0] FUNC_BURST_DONE   = 4'd7;
   localparam logic [3:0] FUNC_BURST_EXPIRE = 4'd8;
   localparam logic [3:0] FUNC_PLAY         = 4'd9;
   localparam logic [3:0] FUNC_PAUSE        = 4'd10;
   localparam logic [3:0] FUNC_TOGGLE       = 4'd11;
   localparam logic [3:0] FUNC_STREAM_START = 4'd12;
   localparam logic [3:0] FUNC_STREAM_STOP  = 4'd13;

   // modes
   localparam logic [1:0] MODE_IDLE      = 2'd0;
   localparam logic [1:0] MODE_PULSING   = 2'd1;
   localparam logic [1:0] MODE_PAUSED    = 2'd2;
   localparam logic [1:0] MODE_STREAMING = 2'd3;

   // play states
   localparam logic [1:0] TS_IDLE    = 2'd0;
   localparam logic [1:0] TS_RUNNING = 2'd1;
   localparam logic [1:0] TS_HELD    = 2'd2;

   // action codes
   localparam logic [3:0] ACT_NONE          = 4'd0;
   localparam logic [3:0] ACT_NEXT_PATTERN  = 4'd1;
   localparam logic [3:0] ACT_NAMED_PATTERN = 4'd2;
   localparam logic [3:0] ACT_QUEUE_CHANGED = 4'd3;
   localparam logic [3:0] ACT_START_PATTERN = 4'd4;
   localparam logic [3:0] ACT_PATTERN_BURST = 4'd5;
   localparam logic [3:0] ACT_START_STREAM  = 4'd6;
   localparam logic [3:0] ACT_STREAM_BURST  = 4'd7;
   localparam logic [3:0] ACT_PAUSE_CLOCK   = 4'd8;
   localparam logic [3:0] ACT_RESUME_CLOCK  = 4'd9;
   localparam logic [3:0] ACT_STREAM_STOP   = 4'd10;
   localparam logic [3:0] ACT_ADC_REPORT    = 4'd11;

   // scaling
   localparam logic [7:0]  INTENSITY_RESET = 8'd16;
   localparam logic [6:0]  VOLT_STEP       = 7'd80;
   localparam logic [8:0]  PW_BASE         = 9'd50;
   localparam logic [15:0] VOLT_ADC_SCALE  = 16'd52813;
   localparam int          VOLT_ADC_SHIFT  = 14;
   localparam logic [11:0] CUR_ADC_SCALE   = 12'd2063;
   localparam int          CUR_ADC_SHIFT   = 10;

   typedef struct packed {
      logic [3:0]  func;
      logic        pattern_found;
      logic        pattern_ready;
      logic        queue_empty;
      logic        burst_scheduled;
      logic        pattern_done;
      logic        descriptor_accepted;
      logic [7:0]  intensity_in;
      logic [11:0] adc_battery;
      logic [11:0] adc_capacitor;
      logic [11:0] adc_current;
   } ptp_req_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  transport_state;
      logic [3:0]  action;
      logic [7:0]  intensity;
      logic [14:0] primary_voltage_mv;
      logic [8:0]  pulse_width;
      logic [13:0] battery_mv;
      logic [13:0] capacitor_mv;
      logic [13:0] primary_ma;
   } ptp_rsp_type;

endpackage

>>> src/ptp_channels.sv
interface ptp_req_if;
   logic                  valid;
   logic                  ready;
   ptp_pkg::ptp_req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ptp_rsp_if;
   logic                  valid;
   logic                  ready;
   ptp_pkg::ptp_rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ptp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/pulse_train_play_controller.sv
// Play controller for pulse trains: every event item on req_chan gives exactly one result item
// on rsp_chan carrying the mode (idle, pulsing, paused, streaming), the play state, one action
// code, the intensity with its voltage set point (intensity * 80 mV) and pulse width, and, for
// the adc event only, the scaled battery, capacitor and current readings. An item passes an
// input register and then an output register; one item is taken every cycle as long as the
// result side keeps up, and a stalled result holds while one more item waits in the input
// register. The single register, default_intensity, is written through csr_chan (always
// ready), resets to the same value as the intensity and is applied on every pattern switch;
// write it only while no item is in flight.
module pulse_train_play_controller (
   input logic             clock,
   input logic             reset,
   ptp_req_if.sink         req_chan,
   ptp_rsp_if.source       rsp_chan,
   ptp_csr_if.sink         csr_chan
);

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   ptp_pkg::ptp_req_type  s1_data_ff;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   ptp_pkg::ptp_rsp_type  rsp_data_ff, rsp_data_in;

   // control state
   logic [1:0] mode_ff, mode_in;
   logic [1:0] transport_state_ff, transport_state_in;
   logic       burst_booked_ff, burst_booked_in;
   logic       stream_held_ff, stream_held_in;
   logic [7:0] intensity_ff, intensity_in;
   logic [7:0] default_intensity_ff, default_intensity_in;

   logic       s1_advance;
   logic       req_take;
   logic [3:0] act;
   logic       adc_event;

   // arithmetic on the outgoing values
   logic [14:0] volt_prod;
   logic [8:0]  pulse_sum;
   logic [27:0] bat_prod;
   logic [27:0] cap_prod;
   logic [23:0] cur_prod;

   // the input register moves on when the output register is free or being emptied
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take     = req_chan.valid && req_chan.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_chan.ready);

   // configuration: one register, always accepted
   assign csr_chan.ready       = 1'b1;
   assign default_intensity_in = csr_chan.valid ? csr_chan.data : default_intensity_ff;

   // event decode and mode transitions
   always_comb begin
      logic       go;
      logic [1:0] go_target;
      logic       go_sched;
      logic       go_resume;

      go                 = 1'b0;
      go_target          = ptp_pkg::MODE_IDLE;
      go_sched           = 1'b0;
      go_resume          = 1'b0;
      act                = ptp_pkg::ACT_NONE;
      adc_event          = 1'b0;
      mode_in            = mode_ff;
      transport_state_in = transport_state_ff;
      burst_booked_in    = burst_booked_ff;
      stream_held_in     = stream_held_ff;
      intensity_in       = intensity_ff;

      unique case (s1_data_ff.func) inside
         ptp_pkg::FUNC_STOP: begin
            go = 1'b1;
         end
         ptp_pkg::FUNC_NEXT_PATTERN: begin
            intensity_in = default_intensity_ff;
            act          = ptp_pkg::ACT_NEXT_PATTERN;
            go           = (mode_ff == ptp_pkg::MODE_PAUSED);
         end
         ptp_pkg::FUNC_NAMED: begin
            if (s1_data_ff.pattern_found) begin
               intensity_in = default_intensity_ff;
               act          = ptp_pkg::ACT_NAMED_PATTERN;
               go           = (mode_ff == ptp_pkg::MODE_PAUSED);
            end else begin
               // lookup failed: back to idle from any mode
               go = 1'b1;
            end
         end
         ptp_pkg::FUNC_QUEUE_PT: begin
            if (s1_data_ff.descriptor_accepted) begin
               act = ptp_pkg::ACT_QUEUE_CHANGED;
            end
         end
         ptp_pkg::FUNC_INTENSITY: begin
            intensity_in = s1_data_ff.intensity_in;
         end
         ptp_pkg::FUNC_ADC: begin
            adc_event = 1'b1;
            act       = ptp_pkg::ACT_ADC_REPORT;
         end
         ptp_pkg::FUNC_BURST_START: begin
            if (mode_ff == ptp_pkg::MODE_STREAMING) begin
               burst_booked_in = s1_data_ff.burst_scheduled;
               act             = ptp_pkg::ACT_STREAM_BURST;
            end
         end
         ptp_pkg::FUNC_BURST_EXPIRE: begin
            case (mode_ff)
               ptp_pkg::MODE_STREAMING: go = !burst_booked_ff;
               ptp_pkg::MODE_PAUSED:    go = s1_data_ff.pattern_done;
               ptp_pkg::MODE_PULSING: begin
                  if (s1_data_ff.burst_scheduled) begin
                     act = ptp_pkg::ACT_PATTERN_BURST;
                  end else begin
                     go = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ptp_pkg::FUNC_PLAY, ptp_pkg::FUNC_TOGGLE: begin
            case (mode_ff)
               ptp_pkg::MODE_IDLE: begin
                  go        = s1_data_ff.pattern_ready;
                  go_target = ptp_pkg::MODE_PULSING;
               end
               ptp_pkg::MODE_PAUSED: begin
                  go        = 1'b1;
                  go_target = ptp_pkg::MODE_PULSING;
                  go_resume = 1'b1;
               end
               ptp_pkg::MODE_PULSING: begin
                  go        = (s1_data_ff.func == ptp_pkg::FUNC_TOGGLE);
                  go_target = ptp_pkg::MODE_PAUSED;
               end
               default: begin
                  // streaming: resume a paused stream, toggle pauses a running one
                  if (stream_held_ff) begin
                     transport_state_in = ptp_pkg::TS_RUNNING;
                     stream_held_in     = 1'b0;
                     act                = ptp_pkg::ACT_RESUME_CLOCK;
                  end else if (s1_data_ff.func == ptp_pkg::FUNC_TOGGLE) begin
                     transport_state_in = ptp_pkg::TS_HELD;
                     stream_held_in     = 1'b1;
                     act                = ptp_pkg::ACT_PAUSE_CLOCK;
                  end
               end
            endcase
         end
         ptp_pkg::FUNC_PAUSE: begin
            if (mode_ff == ptp_pkg::MODE_PULSING) begin
               go        = 1'b1;
               go_target = ptp_pkg::MODE_PAUSED;
            end else if (mode_ff == ptp_pkg::MODE_STREAMING && !stream_held_ff) begin
               transport_state_in = ptp_pkg::TS_HELD;
               stream_held_in     = 1'b1;
               act                = ptp_pkg::ACT_PAUSE_CLOCK;
            end
         end
         ptp_pkg::FUNC_STREAM_START: begin
            go        = (mode_ff == ptp_pkg::MODE_IDLE) && !s1_data_ff.queue_empty;
            go_target = ptp_pkg::MODE_STREAMING;
            go_sched  = s1_data_ff.burst_scheduled;
         end
         ptp_pkg::FUNC_STREAM_STOP: begin
            go = (mode_ff == ptp_pkg::MODE_STREAMING);
         end
         default: ;
      endcase

      // mode change: leaving streaming reports the stop, entry actions then take over
      if (go) begin
         if (mode_ff == ptp_pkg::MODE_STREAMING) begin
            act = ptp_pkg::ACT_STREAM_STOP;
         end
         mode_in = go_target;
         case (go_target)
            ptp_pkg::MODE_IDLE: begin
               transport_state_in = ptp_pkg::TS_IDLE;
            end
            ptp_pkg::MODE_PULSING: begin
               transport_state_in = ptp_pkg::TS_RUNNING;
               act = go_resume ? ptp_pkg::ACT_PATTERN_BURST : ptp_pkg::ACT_START_PATTERN;
            end
            ptp_pkg::MODE_PAUSED: begin
               transport_state_in = ptp_pkg::TS_HELD;
            end
            default: begin
               transport_state_in = ptp_pkg::TS_RUNNING;
               burst_booked_in    = go_sched;
               stream_held_in     = 1'b0;
               act                = ptp_pkg::ACT_START_STREAM;
            end
         endcase
      end
   end

   // derived values, one multiplier per product, pulse width by additions
   assign volt_prod = 15'(intensity_in) * 15'(ptp_pkg::VOLT_STEP);
   assign pulse_sum = ptp_pkg::PW_BASE + 9'(intensity_in) + 9'(intensity_in[7:1]);
   assign bat_prod  = 28'(s1_data_ff.adc_battery) * 28'(ptp_pkg::VOLT_ADC_SCALE);
   assign cap_prod  = 28'(s1_data_ff.adc_capacitor) * 28'(ptp_pkg::VOLT_ADC_SCALE);
   assign cur_prod  = 24'(s1_data_ff.adc_current) * 24'(ptp_pkg::CUR_ADC_SCALE);

   always_comb begin
      rsp_data_in.mode               = mode_in;
      rsp_data_in.transport_state    = transport_state_in;
      rsp_data_in.action             = act;
      rsp_data_in.intensity          = intensity_in;
      rsp_data_in.primary_voltage_mv = volt_prod;
      rsp_data_in.pulse_width        = pulse_sum;
      // readings are reported on the adc event only
      rsp_data_in.battery_mv   = adc_event ? bat_prod[ptp_pkg::VOLT_ADC_SHIFT +: 14] : 14'd0;
      rsp_data_in.capacitor_mv = adc_event ? cap_prod[ptp_pkg::VOLT_ADC_SHIFT +: 14] : 14'd0;
      rsp_data_in.primary_ma   = adc_event ? cur_prod[ptp_pkg::CUR_ADC_SHIFT +: 14] : 14'd0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         mode_ff              <= ptp_pkg::MODE_IDLE;
         transport_state_ff   <= ptp_pkg::TS_IDLE;
         burst_booked_ff      <= 1'b0;
         stream_held_ff       <= 1'b0;
         intensity_ff         <= ptp_pkg::INTENSITY_RESET;
         default_intensity_ff <= ptp_pkg::INTENSITY_RESET;
      end else begin
         s1_valid_ff          <= s1_valid_in;
         rsp_valid_ff         <= rsp_valid_in;
         default_intensity_ff <= default_intensity_in;
         // state moves with the item that leaves the input register
         if (s1_advance) begin
            mode_ff            <= mode_in;
            transport_state_ff <= transport_state_in;
            burst_booked_ff    <= burst_booked_in;
            stream_held_ff     <= stream_held_in;
            intensity_ff       <= intensity_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_chan.data;
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // pattern modes always carry their matching play state
   a_idle_state: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ptp_pkg::MODE_IDLE |-> transport_state_ff == ptp_pkg::TS_IDLE)
      else $error("idle mode with non-idle play state");

   a_pulsing_state: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ptp_pkg::MODE_PULSING |-> transport_state_ff == ptp_pkg::TS_RUNNING)
      else $error("pulsing mode not playing");

   a_paused_state: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ptp_pkg::MODE_PAUSED |-> transport_state_ff == ptp_pkg::TS_HELD)
      else $error("paused mode not paused");

   // stream pause flag and play state agree while streaming
   a_stream_pause: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ptp_pkg::MODE_STREAMING |->
         (stream_held_ff == (transport_state_ff == ptp_pkg::TS_HELD)))
      else $error("stream pause flag out of step with play state");

   // battery and current readings only on an adc report
   a_adc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.action != ptp_pkg::ACT_ADC_REPORT |->
         rsp_data_ff.battery_mv == 14'd0 && rsp_data_ff.primary_ma == 14'd0)
      else $error("adc readings on a non-adc item");

endmodule
